@@ rtl/core/mrb_pkg.sv @@
// Package for the multi-reader ring buffer: request, operation and status codes,
// field widths and the structs passed between the front and back modules.
// No dependencies.
package mrb_pkg;

    localparam int REQ_W    = 3;
    localparam int SEL_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int OCC_W    = 10;
    localparam int STATUS_W = 2;
    localparam int ENABLE_W = 4;
    localparam int KIND_W   = 3;

    // Reader mask loaded at reset: reader 0 only
    localparam logic [ENABLE_W-1:0] ENABLE_RESET = 4'b0001;

    // Chunk header: 16-bit id, then 16-bit size at offset two
    localparam int HEADER_BYTES = 4;
    localparam logic [1:0] SIZE_OFFSET = 2'd2;

    // Request codes as they arrive on the input channel
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

    // Operation kinds after classification
    localparam logic [KIND_W-1:0] OP_NOP   = 3'd0;
    localparam logic [KIND_W-1:0] OP_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] OP_READ  = 3'd2;
    localparam logic [KIND_W-1:0] OP_CLOSE = 3'd3;
    localparam logic [KIND_W-1:0] OP_QUERY = 3'd4;
    localparam logic [KIND_W-1:0] OP_CLEAR = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLOSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEL_W-1:0]  sel;
        logic              sel_ok;
        logic [BYTE_W-1:0] data;
    } op_t;

    typedef struct packed {
        logic [BYTE_W-1:0]        read_byte;
        logic [STATUS_W-1:0]      status;
        logic                     has_chunk;
        logic [WORD_W-1:0]        chunk_id;
        logic signed [WORD_W-1:0] chunk_size;
        logic [OCC_W-1:0]         occupancy;
        logic [OCC_W-1:0]         max_occupancy;
    } result_t;

endpackage

@@ rtl/core/mrb_ifs.sv @@
// Channel interfaces for the multi-reader ring buffer: request, response and
// configuration write. Depends on mrb_pkg for field widths.
interface mrb_req_if;
    logic                         valid;
    logic                         ready;
    logic [mrb_pkg::REQ_W-1:0]    req_type;
    logic [mrb_pkg::SEL_W-1:0]    reader_sel;
    logic [mrb_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output req_type, output reader_sel, output data_byte,
                    input ready);
    modport sink   (input valid, input req_type, input reader_sel, input data_byte,
                    output ready);
endinterface

interface mrb_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [mrb_pkg::BYTE_W-1:0]          read_byte;
    logic [mrb_pkg::STATUS_W-1:0]        status;
    logic                                has_chunk;
    logic [mrb_pkg::WORD_W-1:0]          chunk_id;
    logic signed [mrb_pkg::WORD_W-1:0]   chunk_size;
    logic [mrb_pkg::OCC_W-1:0]           occupancy;
    logic [mrb_pkg::OCC_W-1:0]           max_occupancy;

    modport source (output valid, output read_byte, output status, output has_chunk,
                    output chunk_id, output chunk_size, output occupancy,
                    output max_occupancy, input ready);
    modport sink   (input valid, input read_byte, input status, input has_chunk,
                    input chunk_id, input chunk_size, input occupancy,
                    input max_occupancy, output ready);
endinterface

interface mrb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mrb_pkg::ENABLE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/mrb_front.sv @@
// Front end of the ring buffer: accept requests, classify them and hold them
// in a two-entry queue for the back end. Depends on mrb_pkg and mrb_ifs.
module mrb_front #(
    parameter int READERS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    mrb_req_if.sink       req,
    output logic          q_valid,
    output mrb_pkg::op_t  q_op,
    input  logic          q_pop
);
    import mrb_pkg::*;

    localparam int Q_DEPTH = 2;

    op_t        op_in;
    op_t        slot_reg [Q_DEPTH];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    // Classify the request; unused codes become a no-op
    always_comb
    begin
        case (req.req_type)
            REQ_WRITE: op_in.kind = OP_WRITE;
            REQ_READ:  op_in.kind = OP_READ;
            REQ_CLOSE: op_in.kind = OP_CLOSE;
            REQ_QUERY: op_in.kind = OP_QUERY;
            REQ_CLEAR: op_in.kind = OP_CLEAR;
            default:   op_in.kind = OP_NOP;
        endcase
        op_in.sel    = req.reader_sel;
        op_in.sel_ok = 32'(req.reader_sel) < READERS;
        op_in.data   = req.data_byte;
    end

    assign req.ready = (count_reg != 2'(Q_DEPTH));
    assign push      = req.valid && req.ready;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (count_reg != 2'd0);
    assign q_op      = slot_reg[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                tail_reg <= ~tail_reg;
            if (pop)
                head_reg <= ~head_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[tail_reg] <= op_in;
    end

endmodule

@@ rtl/core/mrb_back.sv @@
// Back end of the ring buffer: pointers, reader flags, byte store and the
// sequencer that carries out one operation at a time into the result register.
// Depends on mrb_pkg and mrb_ifs.
module mrb_back #(
    parameter int DEPTH   = 1024,
    parameter int READERS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  mrb_pkg::op_t                    q_op,
    output logic                            q_pop,
    input  logic [mrb_pkg::ENABLE_W-1:0]    enable,
    mrb_rsp_if.source                       rsp
);
    import mrb_pkg::*;

    localparam int PW    = $clog2(DEPTH);
    localparam int RI_W  = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int EXT_W = (PW > OCC_W) ? PW : OCC_W;
    localparam logic [PW:0] DEPTH_W = (PW + 1)'(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_HDR  = 3'd2;
    localparam logic [2:0] ST_SIZE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] k);
        logic [PW:0] s;
        s = {1'b0, p} + (PW + 1)'(k);
        if (s >= DEPTH_W)
            s = s - DEPTH_W;
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] occ_of(input logic [PW-1:0] wp, input logic [PW-1:0] rp);
        logic [PW:0] d;
        if (wp >= rp)
            d = {1'b0, wp} - {1'b0, rp};
        else
            d = {1'b0, wp} + DEPTH_W - {1'b0, rp};
        return d[PW-1:0];
    endfunction

    function automatic logic [READERS-1:0] mask_to_open(input logic [ENABLE_W-1:0] mask);
        logic [READERS-1:0] o;
        logic [ENABLE_W-1:0] t;
        for (int i = 0; i < READERS; i++)
        begin
            t    = mask >> i;
            o[i] = (i < ENABLE_W) && t[0];
        end
        return o;
    endfunction

    function automatic logic [OCC_W-1:0] to_occ(input logic [PW-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[OCC_W-1:0];
    endfunction

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [2:0]         state_reg, state_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [PW-1:0]      rp_reg [READERS];
    logic [PW-1:0]      rp_next [READERS];
    logic [READERS-1:0] open_reg, open_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    result_t            res_reg, res_next;
    op_t                op_reg, op_next;
    logic [PW-1:0]      q_rp_reg, q_rp_next;
    logic [PW-1:0]      q_occ_reg, q_occ_next;
    logic [BYTE_W-1:0]  rd_a_reg, rd_b_reg;

    logic               wr_en;
    logic               rd_en;
    logic [PW-1:0]      rd_addr_a, rd_addr_b;
    logic [PW-1:0]      occ_all [READERS];
    logic [PW-1:0]      max_occ;
    logic               full;
    logic [RI_W-1:0]    q_idx, d_idx;
    logic               cur_open;
    logic [PW-1:0]      cur_occ;
    logic [PW-1:0]      cur_rp;
    logic [PW-1:0]      done_occ;
    logic signed [WORD_W-1:0] size_word;
    logic signed [WORD_W+1:0] occ_s;
    logic signed [WORD_W+1:0] need_s;

    // Per-reader occupancy, zero when closed; full check and running maximum
    always_comb
    begin
        full    = 1'b0;
        max_occ = '0;
        for (int i = 0; i < READERS; i++)
        begin
            occ_all[i] = open_reg[i] ? occ_of(wp_reg, rp_reg[i]) : '0;
            if (occ_all[i] == PW'(DEPTH - 1))
                full = 1'b1;
            if (occ_all[i] > max_occ)
                max_occ = occ_all[i];
        end
    end

    assign q_idx    = RI_W'(q_op.sel);
    assign d_idx    = RI_W'(op_reg.sel);
    assign cur_open = q_op.sel_ok && open_reg[q_idx];
    assign cur_occ  = occ_all[q_idx];
    assign cur_rp   = rp_reg[q_idx];
    assign done_occ = op_reg.sel_ok ? occ_all[d_idx] : '0;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // Completeness test on the exact sum, no 16-bit wrap
    assign size_word = {rd_b_reg, rd_a_reg};
    assign occ_s     = $signed({2'b00, WORD_W'(q_occ_reg)});
    assign need_s    = (WORD_W + 2)'(size_word) + (WORD_W + 2)'(HEADER_BYTES);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        op_next        = op_reg;
        q_rp_next      = q_rp_reg;
        q_occ_next     = q_occ_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr_a      = q_rp_reg;
        rd_addr_b      = q_rp_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_op;
                    res_next   = '0;
                    state_next = ST_DONE;
                    case (q_op.kind)
                        OP_WRITE:
                        begin
                            if (full)
                                res_next.status = STATUS_FULL;
                            else
                            begin
                                wr_en   = 1'b1;
                                wp_next = wrap_add(wp_reg, 2'd1);
                            end
                        end
                        OP_READ:
                        begin
                            if (!cur_open)
                                res_next.status = STATUS_CLOSED;
                            else if (cur_occ == '0)
                                res_next.status = STATUS_EMPTY;
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr_a      = cur_rp;
                                rp_next[q_idx] = wrap_add(cur_rp, 2'd1);
                                state_next     = ST_READ;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (!cur_open)
                                res_next.status = STATUS_CLOSED;
                            else
                                open_next[q_idx] = 1'b0;
                        end
                        OP_QUERY:
                        begin
                            if (!cur_open)
                                res_next.status = STATUS_CLOSED;
                            else if (cur_occ == '0)
                                res_next.status = STATUS_EMPTY;
                            else if (cur_occ >= PW'(HEADER_BYTES))
                            begin
                                rd_en      = 1'b1;
                                rd_addr_a  = cur_rp;
                                rd_addr_b  = wrap_add(cur_rp, 2'd1);
                                q_rp_next  = cur_rp;
                                q_occ_next = cur_occ;
                                state_next = ST_HDR;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wp_next = '0;
                            for (int i = 0; i < READERS; i++)
                                rp_next[i] = '0;
                            open_next = open_reg | mask_to_open(enable);
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.read_byte = rd_a_reg;
                state_next         = ST_DONE;
            end
            ST_HDR:
            begin
                res_next.chunk_id = {rd_b_reg, rd_a_reg};
                rd_en             = 1'b1;
                rd_addr_a         = wrap_add(q_rp_reg, SIZE_OFFSET);
                rd_addr_b         = wrap_add(q_rp_reg, SIZE_OFFSET + 2'd1);
                state_next        = ST_SIZE;
            end
            ST_SIZE:
            begin
                res_next.chunk_size = size_word;
                res_next.has_chunk  = (occ_s >= need_s);
                state_next          = ST_DONE;
            end
            ST_DONE:
            begin
                // Load the result once the output slot is free or being drained
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next               = res_reg;
                    out_next.occupancy     = to_occ(done_occ);
                    out_next.max_occupancy = to_occ(max_occ);
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            for (int i = 0; i < READERS; i++)
                rp_reg[i] <= '0;
            open_reg      <= mask_to_open(ENABLE_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        res_reg   <= res_next;
        op_reg    <= op_next;
        q_rp_reg  <= q_rp_next;
        q_occ_reg <= q_occ_next;
    end

    // Byte store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= q_op.data;
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_byte     = out_reg.read_byte;
    assign rsp.status        = out_reg.status;
    assign rsp.has_chunk     = out_reg.has_chunk;
    assign rsp.chunk_id      = out_reg.chunk_id;
    assign rsp.chunk_size    = out_reg.chunk_size;
    assign rsp.occupancy     = out_reg.occupancy;
    assign rsp.max_occupancy = out_reg.max_occupancy;

endmodule

@@ rtl/core/multi_reader_ring_buffer.sv @@
// Top level of the multi-reader ring buffer: reader-enable register, front end
// and back end. Depends on mrb_pkg, mrb_ifs, mrb_front and mrb_back.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  req     | in  | valid / ready    | req_type, reader_sel, data_byte
//  rsp     | out | valid / ready    | read_byte, status, has_chunk, chunk_id,
//          |     |                  | chunk_size, occupancy, max_occupancy
//  cfg     | in  | valid / ready    | data (reader_enable mask)
//
// Sequencer: one request at a time. Write, close, clear and unused codes go idle
// to done, a read passes a read state, a query finding a header the header and
// size states; the byte store's registered read ports give two bytes a cycle.
// Reset: pointers clear and reader 0 opens at once; the byte store has no
// clearing pass, since readers only ever reach bytes that were written.
// Stalls: a two-entry queue keeps taking transfers while the back end works or
// while a finished result waits in the output register, until both entries
// hold requests.
module multi_reader_ring_buffer #(
    parameter int DEPTH   = 1024,
    parameter int READERS = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    mrb_req_if.sink   req,
    mrb_rsp_if.source rsp,
    mrb_cfg_if.sink   cfg
);
    import mrb_pkg::*;

    logic [ENABLE_W-1:0] enable_reg;
    logic                q_valid;
    op_t                 q_op;
    logic                q_pop;

    // The mask takes effect at the next clear; write it only while nothing is
    // in flight
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= ENABLE_RESET;
        else if (cfg.valid && cfg.ready)
            enable_reg <= cfg.data;
    end

    // Front: accept and classify, queue for the back end
    mrb_front #(
        .READERS (READERS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop)
    );

    // Back: hold pointers and bytes, run each operation, drive the result
    mrb_back #(
        .DEPTH   (DEPTH),
        .READERS (READERS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .enable  (enable_reg),
        .rsp     (rsp)
    );

endmodule

@@ rtl/core/mrb_checker.sv @@
// Port-level checks for the multi-reader ring buffer result channel, and the
// bind that attaches them to the top level. Depends on mrb_pkg.
module mrb_checker #(
    parameter int DEPTH = 1024
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [mrb_pkg::BYTE_W-1:0]          read_byte,
    input logic [mrb_pkg::STATUS_W-1:0]        status,
    input logic                                has_chunk,
    input logic [mrb_pkg::WORD_W-1:0]          chunk_id,
    input logic signed [mrb_pkg::WORD_W-1:0]   chunk_size,
    input logic [mrb_pkg::OCC_W-1:0]           occupancy,
    input logic [mrb_pkg::OCC_W-1:0]           max_occupancy
);
    import mrb_pkg::*;

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(status)
            && $stable(has_chunk) && $stable(chunk_id) && $stable(chunk_size)
            && $stable(occupancy) && $stable(max_occupancy))
        else $error("result changed while stalled");

    // A byte is only returned by a successful read
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (read_byte != '0) |-> (status == STATUS_OK))
        else $error("read byte with failing status");

    // Chunk fields only come with a successful query
    a_chunk_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (has_chunk || chunk_id != '0 || chunk_size != '0)
            |-> (status == STATUS_OK))
        else $error("chunk fields with failing status");

    // The selected reader never exceeds the largest occupancy
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (DEPTH > 1024) || (occupancy <= max_occupancy))
        else $error("occupancy above max occupancy");

endmodule

bind multi_reader_ring_buffer mrb_checker #(
    .DEPTH (DEPTH)
) u_mrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .read_byte     (rsp.read_byte),
    .status        (rsp.status),
    .has_chunk     (rsp.has_chunk),
    .chunk_id      (rsp.chunk_id),
    .chunk_size    (rsp.chunk_size),
    .occupancy     (rsp.occupancy),
    .max_occupancy (rsp.max_occupancy)
);

@@ tb/sv/tb_multi_reader_ring_buffer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for multi_reader_ring_buffer: directed rows, a buffer fill with
// pointer wrap, then random chunk traffic under several reader masks.
// Depends on mrb_pkg, mrb_ifs and the RTL of multi_reader_ring_buffer.
module tb_multi_reader_ring_buffer;

    import mrb_pkg::*;

    localparam int     RING_DEPTH   = 1024;
    localparam int     RING_READERS = 4;
    localparam int     CLK_PERIOD   = 12;
    localparam longint LIMIT_CYCLES = 1_000_000;
    localparam int     PRINT_CAP    = 100;

    // Request codes the package leaves unnamed; the block must treat them as no-ops
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI  = 3'd7;

    logic clk;
    logic rst_n;

    mrb_req_if req_ch ();
    mrb_rsp_if rsp_ch ();
    mrb_cfg_if cfg_ch ();

    multi_reader_ring_buffer #(
        .DEPTH   (RING_DEPTH),
        .READERS (RING_READERS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Mirror of the ring: byte store, pointers, open flags and the mask
    // that a clear applies. Pointers are 10 bits, so subtraction and
    // increment wrap exactly as the store does.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]   ring_bytes [RING_DEPTH];
    logic [OCC_W-1:0]    ring_wr;
    logic [OCC_W-1:0]    ring_rd    [RING_READERS];
    logic                ring_open  [RING_READERS];
    logic [ENABLE_W-1:0] ring_mask;

    result_t pending_results [$];
    int      fault_count = 0;
    int      items_sent;
    int      stall_left = 0;
    bit      steady;

    // Unread bytes of one reader; a closed reader counts as empty
    function automatic logic [OCC_W-1:0] unread(input int r);
        if (!ring_open[r])
            return '0;
        return ring_wr - ring_rd[r];
    endfunction

    // Little-endian 16-bit word, wrapping over the end of the store
    function automatic logic [WORD_W-1:0] peek_word(input logic [OCC_W-1:0] pos);
        logic [OCC_W-1:0] nxt;
        nxt = pos + 1'b1;
        return {ring_bytes[nxt], ring_bytes[pos]};
    endfunction

    // Apply one request to the mirror and return the response it must produce
    function automatic result_t ring_apply(input logic [REQ_W-1:0]  kind,
                                           input logic [SEL_W-1:0]  sel,
                                           input logic [BYTE_W-1:0] data);
        result_t          res;
        logic [OCC_W-1:0] held;
        logic [OCC_W-1:0] hdr_pos;
        logic             full;
        int               i;
        res = '0;
        case (kind)
            REQ_WRITE: begin
                full = 1'b0;
                for (i = 0; i < RING_READERS; i++)
                    if (unread(i) == RING_DEPTH - 1)
                        full = 1'b1;
                if (full)
                    res.status = STATUS_FULL;
                else
                begin
                    ring_bytes[ring_wr] = data;
                    ring_wr = ring_wr + 1'b1;
                end
            end
            REQ_READ: begin
                if (!ring_open[sel])
                    res.status = STATUS_CLOSED;
                else if (unread(int'(sel)) == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    res.read_byte = ring_bytes[ring_rd[sel]];
                    ring_rd[sel] = ring_rd[sel] + 1'b1;
                end
            end
            REQ_CLOSE: begin
                if (!ring_open[sel])
                    res.status = STATUS_CLOSED;
                else
                    ring_open[sel] = 1'b0;
            end
            REQ_QUERY: begin
                held = unread(int'(sel));
                if (!ring_open[sel])
                    res.status = STATUS_CLOSED;
                else if (held == 0)
                    res.status = STATUS_EMPTY;
                else if (held >= HEADER_BYTES)
                begin
                    hdr_pos        = ring_rd[sel] + SIZE_OFFSET;
                    res.chunk_id   = peek_word(ring_rd[sel]);
                    res.chunk_size = peek_word(hdr_pos);
                    // exact sum, so a negative size always counts as complete
                    res.has_chunk  = int'(held) >= int'(res.chunk_size) + HEADER_BYTES;
                end
            end
            REQ_CLEAR: begin
                ring_wr = '0;
                for (i = 0; i < RING_READERS; i++)
                begin
                    ring_rd[i]   = '0;
                    ring_open[i] = ring_open[i] | ring_mask[i];
                end
            end
            default: ;
        endcase
        res.occupancy = unread(int'(sel));
        for (i = 0; i < RING_READERS; i++)
            if (unread(i) > res.max_occupancy)
                res.max_occupancy = unread(i);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fault_count++;
        if (fault_count <= PRINT_CAP)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Gap length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Hold valid high across back-to-back transfers; drop it
    // only when a gap is due. Predict at the accepting edge, so the
    // expectation is queued before the response can possibly arrive.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [REQ_W-1:0]  kind,
                             input logic [SEL_W-1:0]  sel,
                             input logic [BYTE_W-1:0] data,
                             input bit                typed = 1'b0,
                             input result_t           want = '0);
        int      gap;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.reader_sel <= sel;
        req_ch.data_byte  <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = ring_apply(kind, sel, data);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Write the reader mask once the block has drained. Every request
    // answers exactly once, so an empty queue plus a short pause means idle.
    task automatic write_mask(input logic [ENABLE_W-1:0] mask);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= mask;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        ring_mask = mask;
    endtask

    // One chunk: id, size, then a body. Most are complete and small; some
    // carry a wild size, some are cut short inside the header or body.
    task automatic emit_frame();
        logic [WORD_W-1:0] id_word;
        logic [WORD_W-1:0] size_word;
        int                hdr_len;
        int                body;
        id_word   = WORD_W'($urandom_range(0, 16'hFFFF));
        size_word = ($urandom_range(0, 5) == 0) ? WORD_W'($urandom_range(0, 16'hFFFF))
                                                : WORD_W'($urandom_range(0, 10));
        hdr_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : HEADER_BYTES;
        if (size_word <= 10)
            body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, size_word) : size_word;
        else
            body = $urandom_range(0, 3);
        if (hdr_len < HEADER_BYTES)
            body = 0;
        send_item(REQ_WRITE, SEL_W'($urandom_range(0, 3)), id_word[7:0]);
        if (hdr_len > 1)
            send_item(REQ_WRITE, SEL_W'($urandom_range(0, 3)), id_word[15:8]);
        if (hdr_len > 2)
            send_item(REQ_WRITE, SEL_W'($urandom_range(0, 3)), size_word[7:0]);
        if (hdr_len > 3)
            send_item(REQ_WRITE, SEL_W'($urandom_range(0, 3)), size_word[15:8]);
        repeat (body)
        begin
            if ($urandom_range(0, 5) == 0)
                send_item(REQ_QUERY, SEL_W'($urandom_range(0, 3)),
                          BYTE_W'($urandom_range(0, 255)));
            send_item(REQ_WRITE, SEL_W'($urandom_range(0, 3)),
                      BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Query a reader, then consume the chunk at its head, capped so a
    // garbage size cannot run away; now and then overrun into empty.
    task automatic drain_reader(input int r);
        logic [OCC_W-1:0] hdr_pos;
        int               avail;
        int               want;
        int               sz;
        send_item(REQ_QUERY, SEL_W'(r), BYTE_W'($urandom_range(0, 255)));
        avail = int'(unread(r));
        if (avail >= HEADER_BYTES)
        begin
            hdr_pos = ring_rd[r] + SIZE_OFFSET;
            sz      = int'($signed(peek_word(hdr_pos)));
            want    = (sz < 0) ? HEADER_BYTES : HEADER_BYTES + sz;
        end
        else
            want = avail;
        if (want > 24)
            want = 24;
        if (want > avail)
            want = avail;
        if ($urandom_range(0, 7) == 0)
            want++;
        repeat (want) send_item(REQ_READ, SEL_W'(r), BYTE_W'($urandom_range(0, 255)));
    endtask

    // Apply a mask through a clear, then mix chunk traffic with noise,
    // closes and clears until the phase has its share of transfers.
    task automatic run_phase(input logic [ENABLE_W-1:0] mask, input int count);
        int start;
        int pick;
        int r;
        write_mask(mask);
        send_item(REQ_CLEAR, SEL_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
        start = items_sent;
        while (items_sent - start < count)
        begin
            steady = ($urandom_range(0, 7) == 0);
            pick   = $urandom_range(0, 19);
            if (pick < 12)
            begin
                emit_frame();
                for (r = 0; r < RING_READERS; r++)
                    if ($urandom_range(0, 3) != 0)
                        drain_reader(r);
            end
            else if (pick < 16)
                repeat ($urandom_range(1, 3))
                    send_item(REQ_W'($urandom_range(REQ_WRITE, REQ_UNUSED_HI)),
                              SEL_W'($urandom_range(0, 3)),
                              BYTE_W'($urandom_range(0, 255)));
            else if (pick < 18)
                send_item(REQ_CLOSE, SEL_W'($urandom_range(0, 3)),
                          BYTE_W'($urandom_range(0, 255)));
            else if (pick < 19)
                send_item(REQ_CLEAR, SEL_W'($urandom_range(0, 3)),
                          BYTE_W'($urandom_range(0, 255)));
            else
                send_item(REQ_QUERY, SEL_W'($urandom_range(0, 3)),
                          BYTE_W'($urandom_range(0, 255)));
        end
        steady = 1'b0;
    endtask

    // Fill reader 0 to the brim, knock on the full buffer, then walk the
    // read pointer to the end of the store so chunk headers straddle the wrap.
    task automatic fill_and_wrap();
        int r;
        write_mask(4'b0001);
        send_item(REQ_CLEAR, 2'd0, 8'h00);
        for (r = 1; r < RING_READERS; r++)
            send_item(REQ_CLOSE, SEL_W'(r), 8'h00);
        repeat (RING_DEPTH + 1)
            send_item(REQ_WRITE, SEL_W'($urandom_range(0, 3)),
                      BYTE_W'($urandom_range(0, 255)));
        send_item(REQ_QUERY, 2'd0, 8'h00);
        repeat (RING_DEPTH - 3) send_item(REQ_READ, 2'd0, BYTE_W'($urandom_range(0, 255)));
        repeat (6) send_item(REQ_WRITE, 2'd0, BYTE_W'($urandom_range(0, 255)));
        repeat (6)
        begin
            send_item(REQ_QUERY, 2'd0, 8'h00);
            send_item(REQ_READ, 2'd0, 8'h00);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed rows. Where typed is set, the response is written in full
    // (read_byte, has_chunk, id and size all zero); other rows go through
    // the mirror like the random traffic.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [SEL_W-1:0]    sel;
        logic [BYTE_W-1:0]   data;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occ;
        logic [OCC_W-1:0]    peak;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // fresh from reset: reader 0 open and empty, the rest closed
        {REQ_READ,       2'd0, 8'h00, 1'b1, STATUS_EMPTY,  10'd0, 10'd0},
        {REQ_QUERY,      2'd0, 8'h00, 1'b1, STATUS_EMPTY,  10'd0, 10'd0},
        {REQ_READ,       2'd1, 8'h00, 1'b1, STATUS_CLOSED, 10'd0, 10'd0},
        {REQ_CLOSE,      2'd2, 8'h00, 1'b1, STATUS_CLOSED, 10'd0, 10'd0},
        {REQ_QUERY,      2'd3, 8'h00, 1'b1, STATUS_CLOSED, 10'd0, 10'd0},
        {REQ_WRITE,      2'd0, 8'hFF, 1'b1, STATUS_OK,     10'd1, 10'd1},
        // short of a header, then a header of id 0x00FF and size one
        {REQ_QUERY,      2'd0, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_WRITE,      2'd0, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_WRITE,      2'd1, 8'h01, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_WRITE,      2'd0, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_QUERY,      2'd0, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_WRITE,      2'd0, 8'hA5, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_QUERY,      2'd0, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_READ,       2'd0, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_CLEAR,      2'd0, 8'h00, 1'b1, STATUS_OK,     10'd0, 10'd0},
        // negative payload size counts as complete
        {REQ_WRITE,      2'd0, 8'h34, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_WRITE,      2'd0, 8'h12, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_WRITE,      2'd0, 8'hFE, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_WRITE,      2'd0, 8'hFF, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_QUERY,      2'd0, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_UNUSED_LO,  2'd1, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_UNUSED_HI,  2'd3, 8'hFF, 1'b0, STATUS_OK,     10'd0, 10'd0},
        // close the last open reader; a write with nobody open still lands
        {REQ_CLOSE,      2'd0, 8'h00, 1'b1, STATUS_OK,     10'd0, 10'd0},
        {REQ_READ,       2'd0, 8'h00, 1'b1, STATUS_CLOSED, 10'd0, 10'd0},
        {REQ_WRITE,      2'd2, 8'h5A, 1'b0, STATUS_OK,     10'd0, 10'd0},
        {REQ_UNUSED_MID, 2'd2, 8'h00, 1'b0, STATUS_OK,     10'd0, 10'd0}
    };

    // ------------------------------------------------------------------
    // Clock and the generous overall limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("** multi_reader_ring_buffer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: check each transfer against the oldest expectation,
    // field by field, then decide whether to stall the next cycles.
    // Signals are sampled at the edge, so only pre-edge values are seen.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : response_check
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with nothing outstanding",
                                longint'(rsp_ch.status), longint'(0));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.read_byte !== want.read_byte)
                    report_mismatch("read_byte", longint'(rsp_ch.read_byte),
                                    longint'(want.read_byte));
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", longint'(rsp_ch.status),
                                    longint'(want.status));
                if (rsp_ch.has_chunk !== want.has_chunk)
                    report_mismatch("has_chunk", longint'(rsp_ch.has_chunk),
                                    longint'(want.has_chunk));
                if (rsp_ch.chunk_id !== want.chunk_id)
                    report_mismatch("chunk_id", longint'(rsp_ch.chunk_id),
                                    longint'(want.chunk_id));
                if (rsp_ch.chunk_size !== want.chunk_size)
                    report_mismatch("chunk_size", longint'(rsp_ch.chunk_size),
                                    longint'(want.chunk_size));
                if (rsp_ch.occupancy !== want.occupancy)
                    report_mismatch("occupancy", longint'(rsp_ch.occupancy),
                                    longint'(want.occupancy));
                if (rsp_ch.max_occupancy !== want.max_occupancy)
                    report_mismatch("max_occupancy", longint'(rsp_ch.max_occupancy),
                                    longint'(want.max_occupancy));
            end
        end
        // hold ready low while a stall runs; start a new one now and then
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        result_t want;
        int      row;
        int      r;
        items_sent        = 0;
        steady            = 1'b0;
        rst_n             = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_WRITE;
        req_ch.reader_sel <= '0;
        req_ch.data_byte  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;

        // mirror the reset state: mask of reader 0 only, pointers at zero
        ring_mask = ENABLE_RESET;
        ring_wr   = '0;
        for (r = 0; r < RING_DEPTH; r++)
            ring_bytes[r] = '0;
        for (r = 0; r < RING_READERS; r++)
        begin
            ring_rd[r]   = '0;
            ring_open[r] = ENABLE_RESET[r];
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            want               = '0;
            want.status        = directed_rows[row].status;
            want.occupancy     = directed_rows[row].occ;
            want.max_occupancy = directed_rows[row].peak;
            send_item(directed_rows[row].kind, directed_rows[row].sel,
                      directed_rows[row].data, directed_rows[row].typed, want);
        end

        fill_and_wrap();

        // all readers, none newly opened, scattered masks, then all again
        run_phase(4'b1111, 85);
        run_phase(4'b0000, 85);
        run_phase(4'b0110, 85);
        run_phase(4'b1001, 85);
        run_phase(ENABLE_W'($urandom_range(0, 15)), 85);
        run_phase(4'b1111, 85);

        // drain, then allow a few cycles for any stray response to show
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fault_count == 0)
            $display("** multi_reader_ring_buffer: PASSED **");
        else
            $display("** multi_reader_ring_buffer: FAILED **");
        $finish;
    end

endmodule
